// ----- design/csf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, widths and constants of the class-shape surface fit error unit.
// ----------------------------------------------------------------------------
package csf_pkg;

    // Q16 magnitudes (0 .. 1.0 inclusive) and the field widths
    localparam int Q_W        = 17;
    localparam int H_W        = 16;
    localparam int SUM_W      = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int LO13_W     = 48;

    // shared multiply-add unit: signed A x signed B + C
    localparam int ACC_W  = 36;
    localparam int MB_W   = 18;
    localparam int P_W    = ACC_W + MB_W;

    // weight times binomial coefficient
    localparam int COEF_W = 6;
    localparam int WC_W   = H_W + COEF_W + 1;
    localparam int WIDX_W = 3;

    // root unit working width
    localparam int SQ_W   = 34;

    localparam logic [Q_W-1:0]   ONE_Q16   = 17'h10000;
    localparam logic [P_W-1:0]   RND_Q16   = P_W'(32768);
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic signed [H_W-1:0] H_MAX = 16'sh7FFF;
    localparam logic signed [H_W-1:0] H_MIN = 16'sh8000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UP03 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP47 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LO13 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LO47 = 4'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POW,
        ST_BASM,
        ST_BASW,
        ST_ENV,
        ST_PROD,
        ST_ROUND,
        ST_SQ,
        ST_DONE
    } t_state;

    // binomial coefficient C(n,k) by Pascal rows, for elaboration-time tables
    function automatic int unsigned binom(int unsigned n, int unsigned k);
        int unsigned row [9];
        for (int j = 0; j < 9; j++) begin
            row[j] = (j == 0) ? 1 : 0;
        end
        for (int r = 1; r <= 8; r++) begin
            if (r <= n) begin
                for (int j = 8; j >= 1; j--) begin
                    if (j <= r) begin
                        row[j] = row[j] + row[j-1];
                    end
                end
            end
        end
        return (k <= 8) ? row[k] : 0;
    endfunction

endpackage

// ----- design/csf_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_if
// Handshake channels of the surface fit unit: sample points, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface csf_pt_if import csf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [Q_W-1:0]        chord_pos;
    logic signed [H_W-1:0] target_height;
    logic                  on_lower;
    logic                  last_point;

    modport source (output valid, chord_pos, target_height, on_lower, last_point,
                    input ready);
    modport sink   (input valid, chord_pos, target_height, on_lower, last_point,
                    output ready);
endinterface

interface csf_res_if import csf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [H_W-1:0] surface_height;
    logic [SUM_W-1:0]      error_sum;
    logic                  sum_final;

    modport source (output valid, surface_height, error_sum, sum_final, input ready);
    modport sink   (input valid, surface_height, error_sum, sum_final, output ready);
endinterface

interface csf_cfg_if import csf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/cst_surface_fit_error_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_surface_fit_error_unit
// Evaluates the class-shape airfoil surface at each sample point and keeps a
// running saturated sum of squared errors against the measured height.
//
//  channel  | dir | beat contents
//  ---------+-----+--------------------------------------------------------
//  i_pt     | in  | chord_pos, target_height, on_lower, last_point
//  o_res    | out | surface_height, error_sum, sum_final
//  i_cfg    | in  | index, data (weight registers 0..3, others ignored)
//
//  One point: 2*(NUM_TERMS-1) power steps, 2*NUM_TERMS basis steps, envelope,
//  product, rounding, square, then the result is loaded and the unit returns to
//  idle.
//  The root unit runs beside them; it holds the envelope step below five terms.
//  Reset clears weights, error sum and control; no clearing pass. The next point is
//  taken while a result waits; the last step stalls only while that register is full.
// ----------------------------------------------------------------------------
module cst_surface_fit_error_unit import csf_pkg::*; #(
    parameter int NUM_TERMS = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    csf_pt_if.sink   i_pt,
    csf_res_if.source o_res,
    csf_cfg_if.sink  i_cfg
);

    localparam int IDX_W = $clog2(NUM_TERMS);
    localparam logic [IDX_W-1:0] N_LAST = IDX_W'(NUM_TERMS - 1);

    t_state r_state;
    t_state n_state;

    logic [IDX_W-1:0]        r_idx;
    logic                    r_ph;
    logic [Q_W-1:0]          r_x;
    logic [Q_W-1:0]          r_omx;
    logic signed [H_W-1:0]   r_target;
    logic                    r_lower;
    logic                    r_last;
    logic [Q_W-1:0]          r_px [NUM_TERMS];
    logic [Q_W-1:0]          r_qx [NUM_TERMS];
    logic [Q_W-1:0]          r_m;
    logic signed [WC_W-1:0]  r_wc;
    logic signed [ACC_W-1:0] r_acc;
    logic [Q_W-1:0]          r_env;
    logic signed [P_W-1:0]   r_prod;
    logic signed [H_W-1:0]   r_height;
    logic [31:0]             r_sq;
    logic [SUM_W-1:0]        r_accum;

    logic [CFG_DATA_W-1:0]   r_up03;
    logic [CFG_DATA_W-1:0]   r_up47;
    logic [LO13_W-1:0]       r_lo13;
    logic [CFG_DATA_W-1:0]   r_lo47;

    logic                    r_out_valid;
    logic signed [H_W-1:0]   r_out_height;
    logic [SUM_W-1:0]        r_out_sum;
    logic                    r_out_final;

    logic                    accept;
    logic                    load_out;
    logic [Q_W-1:0]          x_clamp;
    logic [Q_W-1:0]          sqrt_root;
    logic                    sqrt_done;

    logic [COEF_W-1:0]       coef_tab [NUM_TERMS];
    logic [WIDX_W-1:0]       widx;
    logic signed [H_W-1:0]   w_up0;
    logic signed [H_W-1:0]   w_sel;
    logic signed [WC_W-1:0]  wc;
    logic [IDX_W-1:0]        idx_prev;
    logic [IDX_W-1:0]        idx_mirror;

    logic signed [ACC_W-1:0] mac_a;
    logic signed [MB_W-1:0]  mac_b;
    logic signed [P_W-1:0]   mac_c;
    logic signed [P_W-1:0]   mac_sum;
    logic [Q_W-1:0]          mac_rnd;

    logic                    prod_neg;
    logic [P_W-1:0]          prod_mag;
    logic [P_W:0]            mag_rnd;
    logic [P_W-32:0]         mag_hi;
    logic signed [H_W-1:0]   height;
    logic signed [Q_W-1:0]   diff;
    logic [SUM_W:0]          sum_wide;
    logic [SUM_W-1:0]        sum_sat;

    // binomial coefficients of the chosen order
    for (genvar g = 0; g < NUM_TERMS; g++) begin : g_coef
        assign coef_tab[g] = COEF_W'(binom(NUM_TERMS - 1, g));
    end

    // clamp chord position to 1.0
    assign x_clamp = (i_pt.chord_pos > ONE_Q16) ? ONE_Q16 : i_pt.chord_pos;

    assign accept     = i_pt.valid && (r_state == ST_IDLE);
    assign i_pt.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up03 <= '0;
            r_up47 <= '0;
            r_lo13 <= '0;
            r_lo47 <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_UP03: r_up03 <= i_cfg.data;
                CFG_UP47: r_up47 <= i_cfg.data;
                CFG_LO13: r_lo13 <= i_cfg.data[LO13_W-1:0];
                CFG_LO47: r_lo47 <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // weight of the current term, lower first weight is the saturated negation
    assign widx  = WIDX_W'(r_idx);
    assign w_up0 = $signed(r_up03[15:0]);

    always_comb begin
        unique case (widx)
            3'd0: w_sel = !r_lower ? w_up0 : ((w_up0 == H_MIN) ? H_MAX : -w_up0);
            3'd1: w_sel = $signed(r_lower ? r_lo13[15:0]  : r_up03[31:16]);
            3'd2: w_sel = $signed(r_lower ? r_lo13[31:16] : r_up03[47:32]);
            3'd3: w_sel = $signed(r_lower ? r_lo13[47:32] : r_up03[63:48]);
            3'd4: w_sel = $signed(r_lower ? r_lo47[15:0]  : r_up47[15:0]);
            3'd5: w_sel = $signed(r_lower ? r_lo47[31:16] : r_up47[31:16]);
            3'd6: w_sel = $signed(r_lower ? r_lo47[47:32] : r_up47[47:32]);
            3'd7: w_sel = $signed(r_lower ? r_lo47[63:48] : r_up47[63:48]);
            default: w_sel = '0;
        endcase
    end

    assign wc         = w_sel * $signed({1'b0, coef_tab[r_idx]});
    assign idx_prev   = r_idx - IDX_W'(1);
    assign idx_mirror = N_LAST - r_idx;

    // operand selection for the shared unit
    always_comb begin
        mac_a = '0;
        mac_b = '0;
        mac_c = '0;
        unique case (r_state)
            ST_POW: begin
                mac_a = ACC_W'(r_ph ? r_qx[idx_prev] : r_px[idx_prev]);
                mac_b = MB_W'(r_ph ? r_omx : r_x);
                mac_c = RND_Q16;
            end
            ST_BASM: begin
                mac_a = ACC_W'(r_px[r_idx]);
                mac_b = MB_W'(r_qx[idx_mirror]);
                mac_c = RND_Q16;
            end
            ST_BASW: begin
                mac_a = ACC_W'(r_wc);
                mac_b = MB_W'(r_m);
                mac_c = P_W'(r_acc);
            end
            ST_ENV: begin
                mac_a = ACC_W'(sqrt_root);
                mac_b = MB_W'(r_omx);
                mac_c = RND_Q16;
            end
            ST_PROD: begin
                mac_a = r_acc;
                mac_b = MB_W'(r_env);
            end
            ST_SQ: begin
                mac_a = ACC_W'(diff);
                mac_b = MB_W'(diff);
            end
            ST_IDLE, ST_ROUND, ST_DONE: ;
            default: ;
        endcase
    end

    csf_mac u_mac (
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .o_sum (mac_sum)
    );

    assign mac_rnd = mac_sum[Q_W+15:16];

    csf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_x     (x_clamp),
        .o_root  (sqrt_root),
        .o_done  (sqrt_done)
    );

    // height: round half away from zero, then saturate
    assign prod_neg = r_prod[P_W-1];
    assign prod_mag = prod_neg ? (~r_prod + P_W'(1)) : r_prod;
    assign mag_rnd  = {1'b0, prod_mag} + (P_W+1)'(64'h8000_0000);
    assign mag_hi   = mag_rnd[P_W:32];

    always_comb begin
        if (prod_neg) begin
            height = (mag_hi > (P_W-31)'(32768)) ? H_MIN : -$signed(mag_hi[H_W-1:0]);
        end else begin
            height = (mag_hi > (P_W-31)'(32767)) ? H_MAX : $signed(mag_hi[H_W-1:0]);
        end
    end

    assign diff     = Q_W'(r_height) - Q_W'(r_target);
    assign sum_wide = {1'b0, r_accum} + (SUM_W+1)'(r_sq);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    // sequencer: next state
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_POW;
            ST_POW:   if (r_ph && (r_idx == N_LAST)) n_state = ST_BASM;
            ST_BASM:  n_state = ST_BASW;
            ST_BASW:  n_state = (r_idx == N_LAST) ? ST_ENV : ST_BASM;
            ST_ENV:   if (sqrt_done) n_state = ST_PROD;
            ST_PROD:  n_state = ST_ROUND;
            ST_ROUND: n_state = ST_SQ;
            ST_SQ:    n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ph  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_idx <= IDX_W'(1);
                    r_ph  <= 1'b0;
                end
                ST_POW: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_idx <= (r_idx == N_LAST) ? '0 : r_idx + IDX_W'(1);
                    end
                end
                ST_BASW: begin
                    if (r_idx != N_LAST) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_BASM, ST_ENV, ST_PROD, ST_ROUND, ST_SQ, ST_DONE: ;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_x      <= x_clamp;
                    r_omx    <= ONE_Q16 - x_clamp;
                    r_target <= i_pt.target_height;
                    r_lower  <= i_pt.on_lower;
                    r_last   <= i_pt.last_point;
                    r_px[0]  <= ONE_Q16;
                    r_qx[0]  <= ONE_Q16;
                    r_acc    <= '0;
                end
            end
            ST_POW: begin
                if (r_ph) begin
                    r_qx[r_idx] <= mac_rnd;
                end else begin
                    r_px[r_idx] <= mac_rnd;
                end
            end
            ST_BASM: begin
                r_m  <= mac_rnd;
                r_wc <= wc;
            end
            ST_BASW:  r_acc    <= mac_sum[ACC_W-1:0];
            ST_ENV:   r_env    <= mac_rnd;
            ST_PROD:  r_prod   <= mac_sum;
            ST_ROUND: r_height <= height;
            ST_SQ:    r_sq     <= mac_sum[31:0];
            ST_DONE: ;
            default: ;
        endcase
    end

    // error sum: add this point, clear after the last point of an evaluation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
        end else if (load_out) begin
            r_accum <= r_last ? '0 : sum_sat;
        end
    end

    // output register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_height <= r_height;
            r_out_sum    <= sum_sat;
            r_out_final  <= r_last;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.surface_height = r_out_height;
    assign o_res.error_sum      = r_out_sum;
    assign o_res.sum_final      = r_out_final;

    // checks
    a_accept_starts_powers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_POW) && (r_idx == IDX_W'(1)) && !r_ph)
        else $error("accepted point did not start the power steps");

    a_root_ready_for_prod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROD) |-> $past(sqrt_done))
        else $error("height product taken before the root was ready");

    a_root_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> sqrt_done)
        else $error("root unit still busy when a new point arrived");

    a_pow_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POW) |-> (r_idx != '0) && (r_idx <= N_LAST))
        else $error("power step index out of range");

    a_sum_clears_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_last) |=> (r_accum == '0) && o_res.valid && o_res.sum_final)
        else $error("error sum not cleared after the last point");

endmodule

// ----- design/csf_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_mac
// Shared signed multiply-add unit: every product of the sequencer but the weight-coefficient one goes here.
// ----------------------------------------------------------------------------
module csf_mac import csf_pkg::*; (
    input  logic signed [ACC_W-1:0] i_a,
    input  logic signed [MB_W-1:0]  i_b,
    input  logic signed [P_W-1:0]   i_c,
    output logic signed [P_W-1:0]   o_sum
);

    // multiply in full product width, then add the rounding term or accumulator
    assign o_sum = i_a * i_b + i_c;

endmodule

// ----- design/csf_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csf_sqrt
// Digit-by-digit integer square root of x * 2^16, one root bit per cycle.
// ----------------------------------------------------------------------------
module csf_sqrt import csf_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [Q_W-1:0] i_x,
    output logic [Q_W-1:0] o_root,
    output logic           o_done
);

    localparam logic [SQ_W-1:0] BIT_FIRST = SQ_W'(64'h1_0000_0000);

    logic            r_busy;
    logic [SQ_W-1:0] r_v;
    logic [SQ_W-1:0] r_r;
    logic [SQ_W-1:0] r_bit;
    logic [SQ_W-1:0] trial;
    logic            fits;

    assign trial = r_r + r_bit;
    assign fits  = (r_v >= trial);

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
        end
    end

    // load the radicand, then take one digit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= SQ_W'({i_x, 16'h0000});
            r_r   <= '0;
            r_bit <= BIT_FIRST;
        end else if (r_busy) begin
            if (fits) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_r[Q_W-1:0];
    assign o_done = !r_busy;

endmodule

// ----- sim/tb_cst_surface_fit_error_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cst_surface_fit_error_unit
// Self-checking bench for the surface fit error unit. Sample points are sent
// in bursts and the result channel stalls on its own pattern. A predictor
// evaluates the class-shape surface and the running error sum in fixed point
// for every accepted point. Results are checked in order against it, over
// several weight settings that include the extremes.
// ----------------------------------------------------------------------------
module tb_cst_surface_fit_error_unit import csf_pkg::*; ();

    localparam int NT           = 8;
    localparam int POINT_CYCLES = 4 * NT + 4;
    localparam int DRAIN_CYCLES = 2 * POINT_CYCLES;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SHOWN_ERRORS = 10;
    localparam int PHASES       = 7;
    localparam int PHASE_POINTS = 220;

    typedef struct packed {
        logic [Q_W-1:0]        chord_pos;
        logic signed [H_W-1:0] target_height;
        logic                  on_lower;
        logic                  last_point;
    } t_point;

    typedef struct packed {
        logic signed [H_W-1:0] surface_height;
        logic [SUM_W-1:0]      error_sum;
        logic                  sum_final;
    } t_result;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_PATTERN,
        RX_RANDOM
    } t_rx_mode;

    // ------------------------------------------------------------------------
    // Surface predictor and store of expected results
    // ------------------------------------------------------------------------
    class surface_fit_predictor;
        logic [CFG_DATA_W-1:0] weight_reg [4];
        logic [SUM_W-1:0]      err_acc;
        t_result               pending_results [$];
        int unsigned           failures;

        function new();
            foreach (weight_reg[k]) weight_reg[k] = '0;
            err_acc  = '0;
            failures = 0;
        endfunction

        // ignore indexes past the last register; the lower 1..3 word is 48 bits
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx > CFG_LO47) return;
            if (idx == CFG_LO13) data[CFG_DATA_W-1:LO13_W] = '0;
            weight_reg[idx] = data;
        endfunction

        function longint unsigned q16_mul(longint unsigned a, longint unsigned b);
            return (a * b + 64'd32768) >> 16;
        endfunction

        // bitwise root search; the root of a Q32 value of at most 1.0 fits 17 bits
        function longint unsigned q16_root(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = Q_W - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v) root = trial;
            end
            return root;
        endfunction

        // lower weight 0 mirrors upper weight 0, saturating on the negative limit
        function int weight_for(logic lower, int i);
            logic signed [H_W-1:0] w;
            if (i == 0) begin
                w = weight_reg[CFG_UP03][H_W-1:0];
                if (!lower) return w;
                return (w == H_MIN) ? int'(H_MAX) : -int'(w);
            end
            if (!lower) begin
                w = (i < 4) ? weight_reg[CFG_UP03][H_W*i +: H_W]
                            : weight_reg[CFG_UP47][H_W*(i-4) +: H_W];
            end else begin
                w = (i < 4) ? weight_reg[CFG_LO13][H_W*(i-1) +: H_W]
                            : weight_reg[CFG_LO47][H_W*(i-4) +: H_W];
            end
            return w;
        endfunction

        // evaluate the surface at one point and queue its result
        function void note_point(t_point pt);
            longint unsigned x, omx, coef, basis, env_q, mag, sq, total;
            longint unsigned pw [NT];
            longint unsigned qw [NT];
            longint          acc, prod;
            int              height, diff;
            t_result         want;
            x = pt.chord_pos;
            if (x > ONE_Q16) x = ONE_Q16;
            omx = ONE_Q16 - x;
            pw[0] = ONE_Q16;
            qw[0] = ONE_Q16;
            for (int i = 1; i < NT; i++) begin
                pw[i] = q16_mul(pw[i-1], x);
                qw[i] = q16_mul(qw[i-1], omx);
            end
            coef = 1;
            acc  = 0;
            for (int i = 0; i < NT; i++) begin
                basis = coef * q16_mul(pw[i], qw[NT-1-i]);
                acc   = acc + longint'(weight_for(pt.on_lower, i)) * longint'(basis);
                coef  = coef * longint'(NT - 1 - i) / longint'(i + 1);
            end
            env_q = q16_mul(q16_root(x << 16), omx);
            prod  = acc * longint'(env_q);
            mag   = (prod < 0) ? -prod : prod;
            mag   = (mag + (64'd1 << 31)) >> 32;
            if (prod < 0) begin
                height = (mag > longint'(-int'(H_MIN))) ? int'(H_MIN) : -int'(mag);
            end else begin
                height = (mag > longint'(H_MAX)) ? int'(H_MAX) : int'(mag);
            end
            // squared error into the saturating sum
            diff  = height - int'(pt.target_height);
            if (diff < 0) diff = -diff;
            sq    = longint'(diff) * longint'(diff);
            total = longint'(err_acc) + sq;
            err_acc = (total > longint'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
            want.surface_height = height[H_W-1:0];
            want.error_sum      = err_acc;
            want.sum_final      = pt.last_point;
            pending_results.push_back(want);
            if (pt.last_point) err_acc = '0;
        endfunction

        function void check_result(t_result got);
            t_result want;
            string   tag;
            logic    bad;
            if (pending_results.size() == 0) begin
                want = '0;
                bad  = 1'b1;
                tag  = "result with nothing expected";
            end else begin
                want = pending_results.pop_front();
                bad  = (got.surface_height !== want.surface_height) ||
                       (got.error_sum      !== want.error_sum)      ||
                       (got.sum_final      !== want.sum_final);
                tag  = "result mismatch";
            end
            if (bad) begin
                failures++;
                if (failures <= SHOWN_ERRORS) begin
                    $display("%0t %s: exp h %0d s %0d f %0b, got h %0d s %0d f %0b",
                             $realtime, tag, want.surface_height, want.error_sum,
                             want.sum_final, got.surface_height, got.error_sum,
                             got.sum_final);
                end
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    csf_pt_if  pt_if();
    csf_res_if res_if();
    csf_cfg_if cfg_if();

    surface_fit_predictor fit_model = new();

    cst_surface_fit_error_unit #(
        .NUM_TERMS (NT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side: check each beat, stall on a changing pattern
    // ------------------------------------------------------------------------
    t_rx_mode    rx_mode = RX_ALWAYS;
    logic [5:0]  rx_tick = '0;
    logic [15:0] rx_mask = '0;

    initial res_if.ready = 1'b0;

    always @(posedge i_clk) begin : result_side
        t_result got;
        if (res_if.valid && res_if.ready) begin
            got.surface_height = res_if.surface_height;
            got.error_sum      = res_if.error_sum;
            got.sum_final      = res_if.sum_final;
            fit_model.check_result(got);
        end
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick == '1) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_mask <= 16'($urandom);
        end
        case (rx_mode)
            RX_PATTERN: begin
                res_if.ready <= ~rx_mask[rx_tick[3:0]];
            end
            RX_RANDOM: begin
                res_if.ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                res_if.ready <= 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run after too long without any beat
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // hold valid high; the caller lowers it
    task automatic send_cfg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        fit_model.write_reg(idx, data);
    endtask

    // write all four weight words, then a stray write that must be dropped
    task automatic load_weights(input logic [CFG_DATA_W-1:0] up03, up47, lo13, lo47);
        send_cfg(CFG_UP03, up03);
        send_cfg(CFG_UP47, up47);
        send_cfg(CFG_LO13, lo13);
        send_cfg(CFG_LO47, lo47);
        send_cfg(CFG_IDX_W'($urandom_range(int'(CFG_LO47) + 1, (1 << CFG_IDX_W) - 1)),
                 {$urandom, $urandom});
        cfg_if.valid <= 1'b0;
    endtask

    // hold valid high; the caller lowers it
    task automatic send_point(input t_point pt);
        pt_if.valid         <= 1'b1;
        pt_if.chord_pos     <= pt.chord_pos;
        pt_if.target_height <= pt.target_height;
        pt_if.on_lower      <= pt.on_lower;
        pt_if.last_point    <= pt.last_point;
        do @(posedge i_clk); while (!pt_if.ready);
        fit_model.note_point(pt);
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        pt_if.valid <= 1'b0;
        while (fit_model.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_point make_point(input logic [Q_W-1:0] x,
                                          input logic signed [H_W-1:0] target,
                                          input logic lower, input logic closes);
        t_point pt;
        pt.chord_pos     = x;
        pt.target_height = target;
        pt.on_lower      = lower;
        pt.last_point    = closes;
        return pt;
    endfunction

    // mostly inside the chord, some past 1.0, some on the ends
    function automatic t_point random_point(input logic closes);
        logic [Q_W-1:0]        x;
        logic signed [H_W-1:0] target;
        int unsigned           pick;
        int unsigned           offset;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            x = '0;
        end else if (pick == 1) begin
            x = ONE_Q16;
        end else if (pick < 4) begin
            x = Q_W'($urandom_range(int'(ONE_Q16) + 1, (1 << Q_W) - 1));
        end else begin
            x = Q_W'($urandom_range(0, int'(ONE_Q16)));
        end
        offset = $urandom_range(0, 8191);
        target = $urandom_range(0, 1) ? H_W'($urandom) : H_W'(int'(offset) - 4096);
        return make_point(x, target, 1'($urandom), closes);
    endfunction

    // evaluations of random length, sent in bursts with random gaps
    task automatic run_points(input int unsigned count);
        int unsigned eval_left;
        int unsigned burst_left;
        logic        closes;
        eval_left  = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 8);
        for (int unsigned k = 0; k < count; k++) begin
            closes = (eval_left == 1);
            // stray end marks now and then
            if ($urandom_range(0, 9) == 0) closes = 1'($urandom);
            send_point(random_point(closes));
            eval_left = (eval_left == 1) ? $urandom_range(1, 12) : eval_left - 1;
            if (burst_left == 1) begin
                pt_if.valid <= 1'b0;
                repeat ($urandom_range(1, 48)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] words [4];
        i_rst_n             = 1'b0;
        pt_if.valid         = 1'b0;
        pt_if.chord_pos     = '0;
        pt_if.target_height = '0;
        pt_if.on_lower      = 1'b0;
        pt_if.last_point    = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset weights give a flat surface
        send_point(make_point(Q_W'(32768), H_MAX, 1'b0, 1'b1));
        settle();

        // upper weight 0 at the negative limit, so lower weight 0 saturates
        load_weights({{3{16'h7FFF}}, 16'h8000}, {4{16'h7FFF}},
                     {3{16'h8000}}, {4{16'h8000}});
        send_point(make_point('0, H_MAX, 1'b0, 1'b0));
        send_point(make_point(ONE_Q16, H_MIN, 1'b1, 1'b0));
        send_point(make_point(ONE_Q16 + 1'b1, '0, 1'b0, 1'b0));
        send_point(make_point('1, H_MIN, 1'b1, 1'b0));
        send_point(make_point(Q_W'(1), H_MAX, 1'b0, 1'b0));
        send_point(make_point(Q_W'(32768), H_MIN, 1'b1, 1'b0));
        send_point(make_point(ONE_Q16 - 1'b1, H_MAX, 1'b0, 1'b1));
        send_point(make_point(Q_W'(16384), '0, 1'b1, 1'b1));
        settle();

        // every weight at the positive limit
        load_weights({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        send_point(make_point(Q_W'(16384), H_MIN, 1'b0, 1'b0));
        send_point(make_point(Q_W'(16384), H_MIN, 1'b1, 1'b0));
        send_point(make_point(Q_W'(6000), H_MAX, 1'b0, 1'b0));
        send_point(make_point(Q_W'(6000), H_MAX, 1'b1, 1'b1));
        settle();

        // all register bits set
        load_weights('1, '1, '1, '1);
        send_point(make_point(Q_W'(21845), H_MAX, 1'b0, 1'b0));
        send_point(make_point(Q_W'(43690), H_MIN, 1'b1, 1'b0));
        send_point(make_point(Q_W'(98304), '0, 1'b1, 1'b1));
        settle();

        // random part over several weight settings, extremes first
        for (int p = 0; p < PHASES; p++) begin
            foreach (words[k]) begin
                case (p)
                    0: words[k] = '0;
                    1: words[k] = '1;
                    2: words[k] = {4{16'h7FFF}};
                    3: words[k] = {4{16'h8000}};
                    default: words[k] = {$urandom, $urandom};
                endcase
            end
            load_weights(words[0], words[1], words[2], words[3]);
            run_points(PHASE_POINTS);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fit_model.failures == 0 && fit_model.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
